[rtl/v3a_pkg.sv]
package v3a_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_W = 32;
  localparam int OP_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_NEG   = 4'd2,
    OP_SCALE = 4'd3,
    OP_DOT   = 4'd4,
    OP_CROSS = 4'd5,
    OP_MAGSQ = 4'd6,
    OP_MAG   = 4'd7,
    OP_NORM  = 4'd8,
    OP_EQUAL = 4'd9
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] az;
    logic signed [FIELD_W-1:0] bx;
    logic signed [FIELD_W-1:0] by;
    logic signed [FIELD_W-1:0] bz;
    logic signed [FIELD_W-1:0] factor;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] rx;
    logic signed [FIELD_W-1:0] ry;
    logic signed [FIELD_W-1:0] rz;
    logic signed [FIELD_W-1:0] rscalar;
    logic                      equal_flag;
    logic                      overflow;
  } out_word_t;

endpackage

[rtl/v3a_lane.sv]
// One component lane: exact products and sums, each stage registered.
module v3a_lane #(
  parameter int WORD_BITS = v3a_pkg::WORD_BITS_DEF,
  parameter int PW        = 2 * WORD_BITS + 2
) (
  input  logic                        clk,
  input  logic signed [WORD_BITS-1:0] p0,
  input  logic signed [WORD_BITS-1:0] p1,
  input  logic signed [WORD_BITS-1:0] q0,
  input  logic signed [WORD_BITS-1:0] q1,
  input  logic                        sub_second,
  output logic signed [PW-1:0]        sum
);
  logic signed [2*WORD_BITS-1:0] m0;
  logic signed [2*WORD_BITS-1:0] m1;
  logic                          sub_q;

  // Register both products
  always_ff @(posedge clk) begin
    m0    <= p0 * q0;
    m1    <= p1 * q1;
    sub_q <= sub_second;
  end

  // Combine the two products
  always_ff @(posedge clk) begin
    if (sub_q) begin
      sum <= PW'(m0) - PW'(m1);
    end else begin
      sum <= PW'(m0) + PW'(m1);
    end
  end
endmodule

[rtl/v3a_sqrt.sv]
// Pipelined integer square root, one result bit per stage, rounded to nearest.
module v3a_sqrt #(
  parameter int NW = 68,
  parameter int RW = NW / 2
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  output logic [RW:0]   root
);
  logic [NW-1:0] rem [RW+1];
  logic [RW-1:0] res [RW+1];
  logic [NW-1:0] src [RW+1];

  assign rem[0] = '0;
  assign res[0] = '0;
  assign src[0] = num;

  // Restoring square root, one bit per stage
  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [NW-1:0] r_sh;
    logic [NW-1:0] trial;
    always_comb begin
      r_sh  = {rem[s][NW-3:0], src[s][NW-1 -: 2]};
      trial = {(NW-2)'(res[s]), 2'b01};
    end
    always_ff @(posedge clk) begin
      src[s+1] <= src[s] << 2;
      if (r_sh >= trial) begin
        rem[s+1] <= r_sh - trial;
        res[s+1] <= {res[s][RW-2:0], 1'b1};
      end else begin
        rem[s+1] <= r_sh;
        res[s+1] <= {res[s][RW-2:0], 1'b0};
      end
    end
  end

  // Round up when remainder exceeds root
  always_ff @(posedge clk) begin
    root <= (rem[RW] > NW'(res[RW])) ? ({1'b0, res[RW]} + 1'b1) : {1'b0, res[RW]};
  end
endmodule

[rtl/v3a_div.sv]
// Pipelined restoring divider: unsigned quotient, one bit per stage.
module v3a_div #(
  parameter int NW = 66,
  parameter int DW = 36,
  parameter int QW = 34
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  localparam int RW = DW + 1;
  logic [RW-1:0] rem [NW+1];
  logic [NW-1:0] src [NW+1];
  logic [DW-1:0] dd  [NW+1];
  logic [QW-1:0] q   [NW+1];

  assign rem[0] = '0;
  assign src[0] = num;
  assign dd[0]  = den;
  assign q[0]   = '0;

  // One quotient bit each stage
  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [RW-1:0] r_sh;
    logic          ge;
    always_comb begin
      r_sh = {rem[s][RW-2:0], src[s][NW-1]};
      ge   = r_sh >= RW'(dd[s]);
    end
    always_ff @(posedge clk) begin
      src[s+1] <= src[s] << 1;
      dd[s+1]  <= dd[s];
      rem[s+1] <= ge ? r_sh - RW'(dd[s]) : r_sh;
      q[s+1]   <= {q[s][QW-2:0], ge};
    end
  end

  assign quo = q[NW];
endmodule

[rtl/vector3_alu.sv]
// vector3_alu: stateless three-component vector unit in signed fixed point.
// Raise start with an input word on in_word; busy is always low, so a word
// is taken every cycle. Each word yields exactly one result word on out_word,
// marked by done for one cycle; the receiver cannot stall it.
// Operations: add, sub, neg, scale, dot, cross, magsq, mag, normalize, equal.
// Fields out of range saturate and set overflow; undefined ops give zero.
// Every op passes through the same pipeline: each lane registers its products
// and its sum, the three-lane sum is registered, the square root pipeline adds
// WORD_BITS+3 stages, the normalize divide adds one operand register and
// FRAC_BITS+WORD_BITS+2 quotient stages, and the merge adds one output register.
// The default parameters give the Q16.16 format.
// Throughput is one word per cycle; every stage is a plain pipeline register.
// Reset clears the valid pipeline only; data in flight is dropped.
module vector3_alu #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = v3a_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  v3a_pkg::in_word_t  in_word,
  output logic               done,
  output v3a_pkg::out_word_t out_word
);
  localparam int W    = WORD_BITS;
  localparam int FW   = v3a_pkg::FIELD_W;
  localparam int PW   = 2 * W + 2;
  localparam int SW   = 2 * W + 4;
  localparam int RTW  = SW / 2;
  localparam int NUMW = W + FRAC_BITS + 2;
  localparam int DENW = RTW + 2;
  localparam int QW   = W + FRAC_BITS + 2;
  localparam int LAT_A = 3;
  localparam int LAT_S = RTW + 1;
  localparam int LAT_D = NUMW;
  localparam int LAT   = LAT_A + LAT_S + 1 + LAT_D + 1;
  localparam logic signed [PW+1:0] WMAXP = (PW+2)'((64'sd1 <<< (W - 1)) - 1);
  localparam logic signed [PW+1:0] WMINP = -WMAXP - 1;

  typedef struct packed {
    logic            vld;
    logic [3:0]      op;
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] b;
  } ctl_t;

  assign busy = 1'b0;

  logic signed [W-1:0] ai [3];
  logic signed [W-1:0] bi [3];
  logic signed [W-1:0] fi;
  assign ai[0] = in_word.ax[W-1:0];
  assign ai[1] = in_word.ay[W-1:0];
  assign ai[2] = in_word.az[W-1:0];
  assign bi[0] = in_word.bx[W-1:0];
  assign bi[1] = in_word.by[W-1:0];
  assign bi[2] = in_word.bz[W-1:0];
  assign fi    = in_word.factor[W-1:0];

  // Lane operand select: cross uses a[j]b[k]-a[k]b[j], others a*b, a*a, a*f
  logic signed [W-1:0] lp0 [3];
  logic signed [W-1:0] lp1 [3];
  logic signed [W-1:0] lq0 [3];
  logic signed [W-1:0] lq1 [3];
  logic signed [PW-1:0] lsum [3];
  logic signed [PW-1:0] mag_sum;
  logic                 is_cross;
  assign is_cross = in_word.op == v3a_pkg::OP_CROSS;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    always_comb begin
      lp1[i] = '0;
      lq1[i] = '0;
      lp0[i] = ai[i];
      unique case (in_word.op) inside
        v3a_pkg::OP_SCALE: lq0[i] = fi;
        v3a_pkg::OP_CROSS: begin
          lp0[i] = ai[(i + 1) % 3];
          lq0[i] = bi[(i + 2) % 3];
          lp1[i] = ai[(i + 2) % 3];
          lq1[i] = bi[(i + 1) % 3];
        end
        v3a_pkg::OP_MAGSQ, v3a_pkg::OP_MAG, v3a_pkg::OP_NORM: lq0[i] = ai[i];
        default: lq0[i] = bi[i];
      endcase
    end
    v3a_lane #(.WORD_BITS(W), .PW(PW)) u_lane (
      .clk(clk), .p0(lp0[i]), .p1(lp1[i]), .q0(lq0[i]), .q1(lq1[i]),
      .sub_second(is_cross), .sum(lsum[i])
    );
  end

  // Control and operand delay line
  ctl_t ctl [LAT];
  always_comb begin
    ctl[0].vld = start;
    ctl[0].op  = in_word.op;
    for (int i = 0; i < 3; i++) begin
      ctl[0].a[i] = ai[i];
      ctl[0].b[i] = bi[i];
    end
  end
  for (genvar s = 0; s < LAT - 1; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1].vld <= 1'b0;
      end else begin
        ctl[s+1].vld <= ctl[s].vld;
      end
      ctl[s+1].op <= ctl[s].op;
      ctl[s+1].a  <= ctl[s].a;
      ctl[s+1].b  <= ctl[s].b;
    end
  end

  // Merge: three-lane sum, registered
  logic signed [PW-1:0] lsum_q [3];
  always_ff @(posedge clk) begin
    mag_sum <= lsum[0] + lsum[1] + lsum[2];
    for (int i = 0; i < 3; i++) lsum_q[i] <= lsum[i];
  end

  // Square root of the sum of squares
  logic [RTW:0] root;
  v3a_sqrt #(.NW(SW), .RW(RTW)) u_sqrt (
    .clk(clk), .num(SW'(unsigned'(mag_sum))), .root(root)
  );

  // Hold scalar and lane results until the root is ready
  logic signed [PW-1:0] sum_d  [LAT_S+1][3];
  logic signed [PW-1:0] msum_d [LAT_S+1];
  assign msum_d[0] = mag_sum;
  for (genvar i = 0; i < 3; i++) begin : g_ld0
    assign sum_d[0][i] = lsum_q[i];
  end
  for (genvar s = 0; s < LAT_S; s++) begin : g_sd
    always_ff @(posedge clk) begin
      msum_d[s+1] <= msum_d[s];
      for (int i = 0; i < 3; i++) sum_d[s+1][i] <= sum_d[s][i];
    end
  end

  // Normalize divide lanes: (|a|<<(F+1) + m) / (2m)
  logic [RTW:0]  root_q;
  logic [W:0]      amag [3];
  logic [NUMW-1:0] nnum [3];
  logic [QW-1:0]   quo [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = ctl[LAT_A+LAT_S].a[i][W-1] ? -{1'b1, ctl[LAT_A+LAT_S].a[i]}
                                           : {1'b0, ctl[LAT_A+LAT_S].a[i]};
    end
  end
  always_ff @(posedge clk) begin
    root_q <= root;
    for (int i = 0; i < 3; i++) begin
      nnum[i] <= (NUMW'(amag[i]) << (FRAC_BITS + 1)) + NUMW'(root);
    end
  end
  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div #(.NW(NUMW), .DW(DENW), .QW(QW)) u_div (
      .clk(clk), .num(nnum[i]), .den({root_q, 1'b0}), .quo(quo[i])
    );
  end

  // Carry scalar data across the divide
  logic signed [PW-1:0] sum_h  [LAT_D+2][3];
  logic signed [PW-1:0] msum_h [LAT_D+2];
  logic [RTW:0]         root_h [LAT_D+2];
  assign msum_h[0] = msum_d[LAT_S];
  assign root_h[0] = root;
  for (genvar i = 0; i < 3; i++) begin : g_lh0
    assign sum_h[0][i] = sum_d[LAT_S][i];
  end
  for (genvar s = 0; s < LAT_D + 1; s++) begin : g_sh
    always_ff @(posedge clk) begin
      msum_h[s+1] <= msum_h[s];
      root_h[s+1] <= root_h[s];
      for (int i = 0; i < 3; i++) sum_h[s+1][i] <= sum_h[s][i];
    end
  end

  // Saturate a wide signed value
  function automatic logic [W:0] sat_w(input logic signed [PW+1:0] v);
    if (v > WMAXP) return {1'b1, WMAXP[W-1:0]};
    if (v < WMINP) return {1'b1, WMINP[W-1:0]};
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic signed [PW+1:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW+1:0] t;
    t = (PW+2)'(v) + ((PW+2)'(1) <<< (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

  // Final merge and saturation per op
  ctl_t          cf;
  logic [W:0]    sv [3];
  logic [W:0]    ss;
  logic          eq;
  logic signed [PW+1:0] vin [3];
  logic signed [PW+1:0] sin;
  assign cf = ctl[LAT-1];
  always_comb begin
    for (int i = 0; i < 3; i++) vin[i] = '0;
    sin = '0;
    eq  = 1'b0;
    unique case (cf.op) inside
      v3a_pkg::OP_ADD: for (int i = 0; i < 3; i++)
        vin[i] = (PW+2)'(signed'(cf.a[i])) + (PW+2)'(signed'(cf.b[i]));
      v3a_pkg::OP_SUB: for (int i = 0; i < 3; i++)
        vin[i] = (PW+2)'(signed'(cf.a[i])) - (PW+2)'(signed'(cf.b[i]));
      v3a_pkg::OP_NEG: for (int i = 0; i < 3; i++)
        vin[i] = -(PW+2)'(signed'(cf.a[i]));
      v3a_pkg::OP_SCALE, v3a_pkg::OP_CROSS: for (int i = 0; i < 3; i++)
        vin[i] = rnd(sum_h[LAT_D+1][i]);
      v3a_pkg::OP_DOT:   sin = rnd(msum_h[LAT_D+1]);
      v3a_pkg::OP_MAGSQ: sin = rnd(msum_h[LAT_D+1]);
      v3a_pkg::OP_MAG:   sin = (PW+2)'(root_h[LAT_D+1]);
      v3a_pkg::OP_NORM: if (root_h[LAT_D+1] != '0) begin
        for (int i = 0; i < 3; i++)
          vin[i] = cf.a[i][W-1] ? -(PW+2)'(quo[i]) : (PW+2)'(quo[i]);
      end
      v3a_pkg::OP_EQUAL: eq = cf.a == cf.b;
      default: ;
    endcase
    for (int i = 0; i < 3; i++) sv[i] = sat_w(vin[i]);
    ss = sat_w(sin);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cf.vld;
    end
    out_word.rx         <= FW'(signed'(sv[0][W-1:0]));
    out_word.ry         <= FW'(signed'(sv[1][W-1:0]));
    out_word.rz         <= FW'(signed'(sv[2][W-1:0]));
    out_word.rscalar    <= FW'(signed'(ss[W-1:0]));
    out_word.equal_flag <= eq;
    out_word.overflow   <= sv[0][W] | sv[1][W] | sv[2][W] | ss[W];
  end
endmodule
